// ----- rtl/clipped_pixel_alpha_blend_defines.svh -----
// Assertion macros for the top-level RTL file.
`ifndef CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH
`define CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPAB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpab assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpab assertion failed");

`endif

// ----- rtl/cpab_pkg.sv -----
`timescale 1ns / 1ps

package cpab_pkg;

    localparam int unsigned COORD_BITS_DEFAULT = 14;
    localparam int unsigned MID_DEPTH_DEFAULT  = 2;
    localparam int unsigned OUT_DEPTH_DEFAULT  = 4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH_WORDS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_ATTACHED = 3'd5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] COV_FULL     = 8'd255;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [23:0]        source_colour;
        logic [7:0]         coverage;
        logic [31:0]        destination_pixel;
    } item_t;

    typedef struct packed {
        logic        write_enable;
        logic [27:0] word_address;
        logic [31:0] new_pixel;
    } result_t;

    typedef struct packed {
        logic [13:0] clip_left;
        logic [13:0] clip_top;
        logic [14:0] clip_right;
        logic [14:0] clip_bottom;
        logic [13:0] row_pitch_words;
        logic        surface_attached;
    } cfg_t;

    typedef struct packed {
        logic [23:0] source_colour;
        logic [7:0]  coverage;
        logic [23:0] destination_rgb;
    } blend_t;

    // A coordinate that passes the clip test is below 2^coord_bits and below 2^15.
    function automatic int unsigned coord_width(input int unsigned coord_bits);
        return (coord_bits < 15) ? coord_bits : 15;
    endfunction

endpackage

// ----- rtl/cpab_fifo.sv -----
`timescale 1ns / 1ps

module cpab_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic                         empty,
    output logic [WIDTH-1:0]             rdata,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int unsigned PW   = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/cpab_front.sv -----
`timescale 1ns / 1ps

module cpab_front #(
    parameter int unsigned COORD_BITS = cpab_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  cpab_pkg::cfg_t                                    cfg,
    input  logic                                              push,
    input  cpab_pkg::item_t                                   item,
    output logic                                              full,
    output logic                                              valid,
    input  logic                                              queue_full,
    output logic                                              write,
    output logic [cpab_pkg::coord_width(COORD_BITS)-1:0]      x,
    output logic [cpab_pkg::coord_width(COORD_BITS)-1:0]      y,
    output cpab_pkg::blend_t                                  blend
);

    import cpab_pkg::*;

    localparam int unsigned CW    = coord_width(COORD_BITS);
    localparam logic [16:0] LIMIT = 17'(1) << COORD_BITS;

    logic          valid_reg;
    logic          valid_next;
    logic          write_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    blend_t        blend_reg;
    logic [16:0]   x_ext;
    logic [16:0]   y_ext;
    logic          x_inside;
    logic          y_inside;
    logic          keep;
    logic          accept;
    logic          advance;

    always_comb
    begin
        x_ext    = {2'b00, item.pos_x[14:0]};
        y_ext    = {2'b00, item.pos_y[14:0]};
        x_inside = !item.pos_x[15] && (x_ext >= 17'(cfg.clip_left))
                   && (x_ext < 17'(cfg.clip_right)) && (x_ext < LIMIT);
        y_inside = !item.pos_y[15] && (y_ext >= 17'(cfg.clip_top))
                   && (y_ext < 17'(cfg.clip_bottom)) && (y_ext < LIMIT);
        keep     = cfg.surface_attached && (item.coverage != 8'd0) && x_inside && y_inside;
    end

    assign full    = valid_reg && queue_full;
    assign accept  = push && !full;
    assign advance = valid_reg && !queue_full;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            write_reg                 <= keep;
            x_reg                     <= item.pos_x[CW-1:0];
            y_reg                     <= item.pos_y[CW-1:0];
            blend_reg.source_colour   <= item.source_colour;
            blend_reg.coverage        <= item.coverage;
            blend_reg.destination_rgb <= item.destination_pixel[23:0];
        end
    end

    assign valid = valid_reg;
    assign write = write_reg;
    assign x     = x_reg;
    assign y     = y_reg;
    assign blend = blend_reg;

endmodule

// ----- rtl/cpab_back.sv -----
`timescale 1ns / 1ps

module cpab_back #(
    parameter int unsigned COORD_BITS = cpab_pkg::COORD_BITS_DEFAULT,
    parameter int unsigned OUT_DEPTH  = cpab_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  cpab_pkg::cfg_t                                    cfg,
    input  logic                                              valid,
    input  logic                                              write,
    input  logic [cpab_pkg::coord_width(COORD_BITS)-1:0]      x,
    input  logic [cpab_pkg::coord_width(COORD_BITS)-1:0]      y,
    input  cpab_pkg::blend_t                                  blend,
    output logic                                              take,
    output logic                                              empty,
    input  logic                                              pop,
    output cpab_pkg::result_t                                 result
);

    import cpab_pkg::*;

    localparam int unsigned CW     = coord_width(COORD_BITS);
    localparam int unsigned PROD_W = CW + 14;
    localparam int unsigned AW     = PROD_W + 1;
    localparam int unsigned CNTW   = $clog2(OUT_DEPTH + 1);

    logic              v1_reg;
    logic              v2_reg;
    logic              w1_reg;
    logic [CW-1:0]     x1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [15:0]       src_prod_reg [3];
    logic [15:0]       dst_prod_reg [3];
    result_t           result_reg;
    logic [15:0]       src_prod_next [3];
    logic [15:0]       dst_prod_next [3];
    logic [7:0]        inv_cov;
    logic [16:0]       sum [3];
    logic [16:0]       scaled [3];
    logic [7:0]        chan [3];
    logic [AW-1:0]     addr_sum;
    result_t           result_next;
    logic [CNTW-1:0]   out_count;
    logic              out_full;
    logic [$bits(result_t)-1:0] out_rdata;

    // The output queue always has a slot for every beat already in the two stages.
    assign take = valid
                  && (({1'b0, out_count} + (CNTW+1)'(v1_reg) + (CNTW+1)'(v2_reg))
                      < (CNTW+1)'(OUT_DEPTH));

    always_comb
    begin
        inv_cov = COV_FULL - blend.coverage;
        for (int i = 0; i < 3; i++)
        begin
            src_prod_next[i] = 16'(blend.source_colour[8*i +: 8]) * 16'(blend.coverage);
            dst_prod_next[i] = 16'(blend.destination_rgb[8*i +: 8]) * 16'(inv_cov);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i]    = 17'(src_prod_reg[i]) + 17'(dst_prod_reg[i]);
            scaled[i] = sum[i] + (sum[i] >> 8) + 17'd1;
            chan[i]   = scaled[i][15:8];
        end
        addr_sum = AW'(prod_reg) + AW'(x1_reg);
        result_next.write_enable = w1_reg;
        result_next.word_address = w1_reg ? 28'(addr_sum) : 28'd0;
        result_next.new_pixel    = w1_reg ? {ALPHA_OPAQUE, chan[2], chan[1], chan[0]} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            w1_reg   <= write;
            x1_reg   <= x;
            prod_reg <= PROD_W'(y) * PROD_W'(cfg.row_pitch_words);
            for (int i = 0; i < 3; i++)
            begin
                src_prod_reg[i] <= src_prod_next[i];
                dst_prod_reg[i] <= dst_prod_next[i];
            end
        end
        if (v1_reg)
        begin
            result_reg <= result_next;
        end
    end

    cpab_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (v2_reg),
        .wdata (result_reg),
        .full  (out_full),
        .pop   (pop),
        .empty (empty),
        .rdata (out_rdata),
        .count (out_count)
    );

    assign result = result_t'(out_rdata);

endmodule

// ----- rtl/clipped_pixel_alpha_blend.sv -----
`timescale 1ns / 1ps

// Clipped source-over pixel blend for ARGB8888 frame buffers. One pixel is accepted per clock
// while full is low, and one result comes out for every pixel, in order: a write with its word
// address (y * row pitch + x) and the blended word with alpha 0xFF, or a dropped beat with all
// fields zero when no surface is attached, coverage is zero or the pixel lies outside the clip
// rectangle. A result passes the classifying front register, the middle queue, two back stages
// (multipliers, then divide by 255 and address add) and the output queue. The back pulls from
// the middle queue only while its output queue has room for the beats in flight, which together
// with the output queue depth keeps one pixel per clock sustained while results are popped
// every clock. The user must write clip and pitch registers only while the block is idle; the
// block itself does not enforce this.
module clipped_pixel_alpha_blend #(
    parameter int unsigned COORD_BITS = cpab_pkg::COORD_BITS_DEFAULT,
    parameter int unsigned MID_DEPTH  = cpab_pkg::MID_DEPTH_DEFAULT,
    parameter int unsigned OUT_DEPTH  = cpab_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  cpab_pkg::item_t                        item,
    output logic                                   full,
    output logic                                   empty,
    input  logic                                   pop,
    output cpab_pkg::result_t                      result,
    input  logic                                   cfg_write,
    input  logic [cpab_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cpab_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import cpab_pkg::*;

`include "clipped_pixel_alpha_blend_defines.svh"

    localparam int unsigned CW      = coord_width(COORD_BITS);
    localparam int unsigned MW      = 1 + 2 * CW + $bits(blend_t);
    localparam int unsigned MCNTW   = $clog2(MID_DEPTH + 1);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          f_valid;
    logic          f_write;
    logic [CW-1:0] f_x;
    logic [CW-1:0] f_y;
    blend_t        f_blend;
    logic          mid_full;
    logic          mid_empty;
    logic [MW-1:0] mid_rdata;
    logic [MCNTW-1:0] mid_count;
    logic          m_write;
    logic [CW-1:0] m_x;
    logic [CW-1:0] m_y;
    blend_t        m_blend;
    logic          b_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CLIP_LEFT:        cfg_next.clip_left        = cfg_data[13:0];
                REG_CLIP_TOP:         cfg_next.clip_top         = cfg_data[13:0];
                REG_CLIP_RIGHT:       cfg_next.clip_right       = cfg_data[14:0];
                REG_CLIP_BOTTOM:      cfg_next.clip_bottom      = cfg_data[14:0];
                REG_ROW_PITCH_WORDS:  cfg_next.row_pitch_words  = cfg_data[13:0];
                REG_SURFACE_ATTACHED: cfg_next.surface_attached = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cpab_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .item       (item),
        .full       (full),
        .valid      (f_valid),
        .queue_full (mid_full),
        .write      (f_write),
        .x          (f_x),
        .y          (f_y),
        .blend      (f_blend)
    );

    cpab_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (MW)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .wdata ({f_write, f_x, f_y, f_blend}),
        .full  (mid_full),
        .pop   (b_take),
        .empty (mid_empty),
        .rdata (mid_rdata),
        .count (mid_count)
    );

    assign {m_write, m_x, m_y, m_blend} = mid_rdata;

    cpab_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .valid  (!mid_empty),
        .write  (m_write),
        .x      (m_x),
        .y      (m_y),
        .blend  (m_blend),
        .take   (b_take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    `CPAB_ASSERT_SAME(a_drop_zero, clk, rst_n, !empty && !result.write_enable,
        result.word_address == 28'd0 && result.new_pixel == 32'd0)
    `CPAB_ASSERT_SAME(a_alpha_opaque, clk, rst_n, !empty && result.write_enable,
        result.new_pixel[31:24] == ALPHA_OPAQUE)
    `CPAB_ASSERT_SAME(a_write_needs_surface, clk, rst_n, f_valid && f_write,
        cfg_reg.surface_attached)
    `CPAB_ASSERT_NEXT(a_zero_cov_dropped, clk, rst_n, push && !full && item.coverage == 8'd0,
        f_valid && !f_write)
    `CPAB_ASSERT_SAME(a_mid_bound, clk, rst_n, 1'b1, mid_count <= MCNTW'(MID_DEPTH))

endmodule

// ----- verif/clipped_pixel_alpha_blend_test.sv -----
`timescale 1ns / 1ps

module clipped_pixel_alpha_blend_test;
    import cpab_pkg::*;

    localparam int COORD_LIMIT = 1 << COORD_BITS_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS = 105;
    localparam int BURST_PIXELS = 48;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    item_t item = '0;
    logic full;
    logic empty;
    logic pop = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    result_t pending_writes[$];
    result_t oldest_write;
    cfg_t clip_cfg = '0;
    bit tx_steady = 1'b0;
    int hold_request = 0;
    int error_count = 0;
    int beats_sent = 0;
    int writes_seen = 0;
    int drops_seen = 0;
    int config_count = 0;
    int full_stall_cycles = 0;
    int cycle_count = 0;

    clipped_pixel_alpha_blend i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic result_t predict_result(input item_t it);
        result_t res;
        int x, y, left, top, right_bound, bottom_bound, pitch;
        int unsigned cov, s, d;
        res = '0;
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        left = clip_cfg.clip_left;
        top = clip_cfg.clip_top;
        right_bound = clip_cfg.clip_right;
        bottom_bound = clip_cfg.clip_bottom;
        pitch = clip_cfg.row_pitch_words;
        cov = it.coverage;
        if (right_bound > COORD_LIMIT)
            right_bound = COORD_LIMIT;
        if (bottom_bound > COORD_LIMIT)
            bottom_bound = COORD_LIMIT;
        if (!clip_cfg.surface_attached || cov == 0)
            return res;
        if (x < left || y < top || x >= right_bound || y >= bottom_bound)
            return res;
        res.write_enable = 1'b1;
        res.word_address = 28'(y * pitch + x);
        if (it.coverage == COV_FULL)
        begin
            res.new_pixel = {ALPHA_OPAQUE, it.source_colour};
        end
        else
        begin
            res.new_pixel[31:24] = ALPHA_OPAQUE;
            for (int ch = 0; ch < 3; ch++)
            begin
                s = it.source_colour[8*ch +: 8];
                d = it.destination_pixel[8*ch +: 8];
                res.new_pixel[8*ch +: 8] =
                    8'((s * cov + d * (int'(COV_FULL) - cov)) / int'(COV_FULL));
            end
        end
        return res;
    endfunction

    function automatic int idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t pixel(input int x, input int y, input logic [23:0] src,
                                    input logic [7:0] cov, input logic [31:0] dst);
        item_t it;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.source_colour = src;
        it.coverage = cov;
        it.destination_pixel = dst;
        return it;
    endfunction

    function automatic item_t random_pixel();
        item_t it;
        int unsigned r;
        int span_x, span_y;
        it.source_colour = 24'($urandom);
        it.destination_pixel = $urandom;
        r = $urandom_range(0, 9);
        if (r < 2)
            it.coverage = COV_FULL;
        else if (r == 2)
            it.coverage = 8'd0;
        else
            it.coverage = 8'($urandom_range(1, 254));
        if ($urandom_range(0, 9) < 8)
        begin
            span_x = (clip_cfg.clip_right > clip_cfg.clip_left) ?
                     int'(clip_cfg.clip_right) - int'(clip_cfg.clip_left) : 0;
            span_y = (clip_cfg.clip_bottom > clip_cfg.clip_top) ?
                     int'(clip_cfg.clip_bottom) - int'(clip_cfg.clip_top) : 0;
            it.pos_x = 16'(int'(clip_cfg.clip_left) - 2 + int'($urandom_range(0, span_x + 3)));
            it.pos_y = 16'(int'(clip_cfg.clip_top) - 2 + int'($urandom_range(0, span_y + 3)));
        end
        else
        begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
        end
        return it;
    endfunction

    function automatic cfg_t random_clip();
        cfg_t c;
        int left, top, right_edge, bottom_edge;
        left = $urandom_range(0, COORD_LIMIT - 1);
        top = $urandom_range(0, COORD_LIMIT - 1);
        right_edge = left + (($urandom_range(0, 3) == 0) ?
                     $urandom_range(0, COORD_LIMIT - left) : $urandom_range(1, 48));
        bottom_edge = top + (($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, COORD_LIMIT - top) : $urandom_range(1, 48));
        c.clip_left = 14'(left);
        c.clip_top = 14'(top);
        c.clip_right = 15'((right_edge > COORD_LIMIT) ? COORD_LIMIT : right_edge);
        c.clip_bottom = 15'((bottom_edge > COORD_LIMIT) ? COORD_LIMIT : bottom_edge);
        c.row_pitch_words = 14'($urandom_range(0, COORD_LIMIT - 1));
        c.surface_attached = ($urandom_range(0, 7) != 0);
        return c;
    endfunction

    task automatic apply_config(input cfg_t c);
        cfg_write <= 1'b1;
        cfg_index <= REG_CLIP_LEFT;
        cfg_data <= CFG_DATA_W'(c.clip_left);
        @(posedge clk);
        cfg_index <= REG_CLIP_TOP;
        cfg_data <= CFG_DATA_W'(c.clip_top);
        @(posedge clk);
        cfg_index <= REG_CLIP_RIGHT;
        cfg_data <= c.clip_right;
        @(posedge clk);
        cfg_index <= REG_CLIP_BOTTOM;
        cfg_data <= c.clip_bottom;
        @(posedge clk);
        cfg_index <= REG_ROW_PITCH_WORDS;
        cfg_data <= CFG_DATA_W'(c.row_pitch_words);
        @(posedge clk);
        cfg_index <= REG_SURFACE_ATTACHED;
        cfg_data <= CFG_DATA_W'(c.surface_attached);
        @(posedge clk);
        // Writes to unmapped indexes must leave every register alone.
        cfg_index <= ($urandom_range(0, 1) == 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI;
        cfg_data <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        clip_cfg = c;
        config_count++;
    endtask

    task automatic send_pixel(input item_t it);
        int gap;
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            full_stall_cycles++;
            @(posedge clk);
        end
        pending_writes.push_back(predict_result(it));
        beats_sent++;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_detached_after_reset();
        send_pixel(pixel(5, 5, 24'hFFFFFF, COV_FULL, 32'h0));
        send_pixel(pixel(0, 0, 24'h123456, 8'd128, 32'hFFFFFFFF));
        send_pixel(pixel(-1, -1, 24'h0, 8'd1, 32'h0));
    endtask

    task automatic test_clip_edges();
        wait_idle();
        apply_config(cfg_t'{14'd10, 14'd20, 15'd100, 15'd50, 14'd640, 1'b1});
        send_pixel(pixel(10, 20, 24'hFFFFFF, COV_FULL, 32'h0));
        send_pixel(pixel(9, 20, 24'hFFFFFF, COV_FULL, 32'h0));
        send_pixel(pixel(10, 19, 24'hFFFFFF, COV_FULL, 32'h0));
        send_pixel(pixel(99, 49, 24'h80FF01, 8'd200, 32'h7F00FE80));
        send_pixel(pixel(100, 49, 24'h80FF01, 8'd200, 32'h7F00FE80));
        send_pixel(pixel(99, 50, 24'h80FF01, 8'd200, 32'h7F00FE80));
        send_pixel(pixel(-32768, -32768, 24'hFFFFFF, COV_FULL, 32'hFFFFFFFF));
        send_pixel(pixel(32767, 32767, 24'hFFFFFF, COV_FULL, 32'hFFFFFFFF));
    endtask

    task automatic test_coverage_and_colour();
        send_pixel(pixel(50, 30, 24'hFFFFFF, 8'd1, 32'h0));
        send_pixel(pixel(51, 30, 24'h000000, 8'd254, 32'hFFFFFFFF));
        send_pixel(pixel(52, 31, 24'hA5A5A5, 8'd128, 32'h5A5A5A5A));
        send_pixel(pixel(53, 32, 24'hFFFFFF, 8'd0, 32'hFFFFFFFF));
        send_pixel(pixel(54, 33, 24'h000000, COV_FULL, 32'hFFFFFFFF));
    endtask

    task automatic test_surface_limits();
        wait_idle();
        apply_config(cfg_t'{14'd0, 14'd0, 15'd16384, 15'd16384, 14'd16383, 1'b1});
        send_pixel(pixel(16383, 16383, 24'h00FF00, COV_FULL, 32'h0));
        send_pixel(pixel(16384, 0, 24'h00FF00, COV_FULL, 32'h0));
        send_pixel(pixel(0, 16384, 24'h00FF00, COV_FULL, 32'h0));
        send_pixel(pixel(0, 0, 24'h102030, 8'd77, 32'hC0D0E0F0));
        send_pixel(pixel(-1, 0, 24'h102030, 8'd77, 32'hC0D0E0F0));
        wait_idle();
        apply_config(cfg_t'{14'd0, 14'd0, 15'd16384, 15'd16384, 14'd0, 1'b1});
        send_pixel(pixel(300, 700, 24'hFEDCBA, 8'd9, 32'h01234567));
    endtask

    task automatic test_empty_clip();
        wait_idle();
        apply_config(cfg_t'{14'd50, 14'd50, 15'd50, 15'd60, 14'd100, 1'b1});
        send_pixel(pixel(50, 55, 24'hFFFFFF, COV_FULL, 32'h0));
        wait_idle();
        apply_config(cfg_t'{14'd60, 14'd10, 15'd40, 15'd20, 14'd100, 1'b1});
        send_pixel(pixel(50, 15, 24'hFFFFFF, COV_FULL, 32'h0));
        wait_idle();
        apply_config(cfg_t'{14'd0, 14'd0, 15'd16384, 15'd16384, 14'd100, 1'b0});
        send_pixel(pixel(5, 5, 24'hFFFFFF, COV_FULL, 32'h0));
    endtask

    task automatic test_backpressure();
        cfg_t c;
        wait_idle();
        c = random_clip();
        c.surface_attached = 1'b1;
        apply_config(c);
        hold_request = LONG_HOLD_CYCLES;
        tx_steady = 1'b1;
        repeat (BURST_PIXELS) send_pixel(random_pixel());
        tx_steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            if (phase == 0)
                apply_config(cfg_t'{14'd0, 14'd0, 15'd16384, 15'd16384, 14'd16383, 1'b1});
            else
                apply_config(random_clip());
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if (i % 35 == 0)
                    tx_steady = ($urandom_range(0, 2) == 0);
                send_pixel(random_pixel());
            end
            tx_steady = 1'b0;
        end
    endtask

    initial
    begin
        int stall_left;
        int steady_left;
        stall_left = 0;
        steady_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (steady_left > 0)
            begin
                pop <= 1'b1;
                steady_left--;
            end
            else
            begin
                stall_left = idle_gap();
                pop <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
                else if ($urandom_range(0, 11) == 0)
                    steady_left = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("result beat with no pixel outstanding");
                error_count++;
            end
            else
            begin
                oldest_write = pending_writes.pop_front();
                if (oldest_write.write_enable)
                    writes_seen++;
                else
                    drops_seen++;
                if (result.write_enable !== oldest_write.write_enable)
                begin
                    $error("write_enable: expected %0d, got %0d",
                           oldest_write.write_enable, result.write_enable);
                    error_count++;
                end
                if (result.word_address !== oldest_write.word_address)
                begin
                    $error("word_address: expected 0x%07h, got 0x%07h",
                           oldest_write.word_address, result.word_address);
                    error_count++;
                end
                if (result.new_pixel !== oldest_write.new_pixel)
                begin
                    $error("new_pixel: expected 0x%08h, got 0x%08h",
                           oldest_write.new_pixel, result.new_pixel);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_detached_after_reset();
        test_clip_edges();
        test_coverage_and_colour();
        test_surface_limits();
        test_empty_clip();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (pending_writes.size() != 0)
        begin
            $error("%0d result beats never arrived", pending_writes.size());
            error_count++;
        end
        $display("Sent %0d pixels over %0d clip settings: %0d written, %0d dropped.",
                 beats_sent, config_count, writes_seen, drops_seen);
        $display("The input was held off by a full block for %0d cycles.", full_stall_cycles);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
